FILE: sv/apc_pkg.sv
`timescale 1ns / 1ps
// Package for asset_price_convert: payload structs, status codes, register map.
// Used by asset_price_convert_top; depends on nothing.
package apc_pkg;

	localparam int AmtW  = 63;
	localparam int IdW   = 48;
	localparam int StW   = 2;
	localparam int DataW = 64;
	localparam int AddrW = 4;

	localparam logic [AmtW-1:0] MaxSupplyRst = 63'd1000000000000000;

	localparam logic [StW-1:0] ST_OK       = 2'd0;
	localparam logic [StW-1:0] ST_DIV_ZERO = 2'd1;
	localparam logic [StW-1:0] ST_OVER     = 2'd2;
	localparam logic [StW-1:0] ST_MISMATCH = 2'd3;

	localparam logic [0:0] REG_MAX_SUPPLY = 1'b0;

	typedef struct packed {
		logic            func;
		logic [AmtW-1:0] amount;
		logic [IdW-1:0]  src_id;
		logic [AmtW-1:0] base_amount;
		logic [IdW-1:0]  base_id;
		logic [AmtW-1:0] quote_amount;
		logic [IdW-1:0]  quote_id;
	} in_t;

	typedef struct packed {
		logic [AmtW-1:0] result_amount;
		logic [IdW-1:0]  result_id;
		logic [StW-1:0]  status;
	} out_t;

	typedef struct packed {
		logic            func;
		logic [AmtW-1:0] divisor;
		logic [IdW-1:0]  rid;
		logic [StW-1:0]  status;
	} meta_t;

endpackage

FILE: sv/asset_price_convert_top.sv
`timescale 1ns / 1ps
// Top level of asset_price_convert: pipelined 63x63 multiply and 126/63 divide.
// Depends on apc_pkg.
//
// Usage: the input channel (in_valid, in_stall, in_data) carries one conversion
// request per transfer; the output channel (out_valid, out_stall, out_data)
// returns exactly one result per request, in order.
// From input transfer to out_valid a request passes through one select stage, a
// partial product stage, a product sum stage, a range check stage, sixteen
// divide stages of four restoring steps each (three in the last), and the
// output register.
// One item per cycle except while stalled; the 63 divide steps set the depth.
// The whole pipeline advances together: while out_valid is high and out_stall
// is high, every stage holds and in_stall is raised, so nothing is lost.
// Reset clears all valid bits and sets max_supply to 1e15.
// max_supply is written through APB when paddr[3] is clear (64-bit data);
// writes with paddr[3] set are ignored. Reads with paddr[3] clear return it.
module asset_price_convert_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  apc_pkg::in_t                in_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output apc_pkg::out_t               out_data,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [apc_pkg::AddrW-1:0]   paddr,
	input  logic [apc_pkg::DataW-1:0]   pwdata,
	output logic [apc_pkg::DataW-1:0]   prdata,
	output logic                        pready
);

	localparam int AW    = apc_pkg::AmtW;
	localparam int PerSt = 4;
	localparam int NDiv  = (AW + PerSt - 1) / PerSt;

	logic [AW-1:0] max_supply_q;
	logic          adv;

	assign pready = 1'b1;
	assign prdata = (paddr[apc_pkg::AddrW-1:3] == 1'(apc_pkg::REG_MAX_SUPPLY)) ?
		{1'b0, max_supply_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_supply_q <= apc_pkg::MaxSupplyRst;
		end else if (psel && penable && pwrite &&
			paddr[apc_pkg::AddrW-1:3] == 1'(apc_pkg::REG_MAX_SUPPLY)) begin
			max_supply_q <= pwdata[AW-1:0];
		end
	end

	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	// stage 1: side select
	logic               vld_s1;
	apc_pkg::meta_t     meta_s1;
	logic [AW-1:0]      mula_s1, mulb_s1;
	apc_pkg::meta_t     meta_c;
	logic [AW-1:0]      mulb_c;

	always_comb begin
		meta_c.func    = in_data.func;
		meta_c.divisor = '0;
		meta_c.rid     = '0;
		meta_c.status  = apc_pkg::ST_OK;
		mulb_c         = '0;
		if (in_data.src_id == in_data.base_id) begin
			mulb_c         = in_data.quote_amount;
			meta_c.divisor = in_data.base_amount;
			meta_c.rid     = in_data.quote_id;
		end else if (in_data.src_id == in_data.quote_id) begin
			mulb_c         = in_data.base_amount;
			meta_c.divisor = in_data.quote_amount;
			meta_c.rid     = in_data.base_id;
		end else begin
			meta_c.status = apc_pkg::ST_MISMATCH;
		end
		if (meta_c.status == apc_pkg::ST_OK && meta_c.divisor == '0) begin
			meta_c.status = apc_pkg::ST_DIV_ZERO;
		end
	end

	// stage 2: partial products
	logic               vld_s2;
	apc_pkg::meta_t     meta_s2;
	logic [63:0]        p00_s2, p01_s2, p10_s2;
	logic [61:0]        p11_s2;

	// stage 3: product sum
	logic               vld_s3;
	apc_pkg::meta_t     meta_s3;
	logic [2*AW-1:0]    prod_s3;

	// stage 4: range check, divide setup
	logic               vld_s4;
	apc_pkg::meta_t     meta_s4;
	logic [2*AW-1:0]    work_s4;
	apc_pkg::meta_t     meta4_c;

	logic [2*AW+1:0]    sum_c;
	assign sum_c = {64'd0, p00_s2} +
		{31'd0, ({1'b0, p01_s2} + {1'b0, p10_s2}), 32'd0} +
		{2'd0, p11_s2, 64'd0};

	always_comb begin
		meta4_c = meta_s3;
		if (meta_s3.status == apc_pkg::ST_OK &&
			prod_s3[2*AW-1:AW] >= meta_s3.divisor) begin
			meta4_c.status = apc_pkg::ST_OVER;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s1 <= meta_c;
			mula_s1 <= in_data.amount;
			mulb_s1 <= mulb_c;
			meta_s2 <= meta_s1;
			p00_s2  <= 64'(mula_s1[31:0]) * 64'(mulb_s1[31:0]);
			p01_s2  <= 64'(mula_s1[31:0]) * 64'(mulb_s1[AW-1:32]);
			p10_s2  <= 64'(mula_s1[AW-1:32]) * 64'(mulb_s1[31:0]);
			p11_s2  <= 62'(mula_s1[AW-1:32]) * 62'(mulb_s1[AW-1:32]);
			meta_s3 <= meta_s2;
			prod_s3 <= sum_c[2*AW-1:0];
			meta_s4 <= meta4_c;
			work_s4 <= prod_s3;
		end
	end

	// divide stages: work = {remainder, numerator bits shifting into quotient}
	logic               vld_src  [NDiv];
	apc_pkg::meta_t     meta_src [NDiv];
	logic [2*AW-1:0]    work_src [NDiv];
	logic               vld_d    [NDiv];
	apc_pkg::meta_t     meta_d   [NDiv];
	logic [2*AW-1:0]    work_d   [NDiv];
	logic [2*AW-1:0]    work_c   [NDiv];

	always_comb begin
		vld_src[0]  = vld_s4;
		meta_src[0] = meta_s4;
		work_src[0] = work_s4;
		for (int k = 1; k < NDiv; k++) begin
			vld_src[k]  = vld_d[k-1];
			meta_src[k] = meta_d[k-1];
			work_src[k] = work_d[k-1];
		end
	end

	always_comb begin
		logic [AW:0]   r2;
		logic [AW-1:0] rr, ll;
		logic          qb;
		r2 = '0;
		qb = 1'b0;
		for (int k = 0; k < NDiv; k++) begin
			rr = work_src[k][2*AW-1:AW];
			ll = work_src[k][AW-1:0];
			for (int j = 0; j < PerSt; j++) begin
				if (k * PerSt + j < AW) begin
					r2 = {rr, ll[AW-1]};
					qb = (r2 >= {1'b0, meta_src[k].divisor});
					if (qb) begin
						r2 = r2 - {1'b0, meta_src[k].divisor};
					end
					rr = r2[AW-1:0];
					ll = {ll[AW-2:0], qb};
				end
			end
			work_c[k] = {rr, ll};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NDiv; k++) begin
				vld_d[k] <= 1'b0;
			end
		end else if (adv) begin
			for (int k = 0; k < NDiv; k++) begin
				vld_d[k] <= vld_src[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < NDiv; k++) begin
				meta_d[k] <= meta_src[k];
				work_d[k] <= work_c[k];
			end
		end
	end

	// output stage: round up, supply check
	logic [AW-1:0] quo, rem;
	logic [AW:0]   qr;
	apc_pkg::out_t res_c;

	assign rem = work_d[NDiv-1][2*AW-1:AW];
	assign quo = work_d[NDiv-1][AW-1:0];
	assign qr  = {1'b0, quo} + {{AW{1'b0}}, (meta_d[NDiv-1].func && rem != '0)};

	always_comb begin
		res_c.result_amount = '0;
		res_c.result_id     = '0;
		res_c.status        = meta_d[NDiv-1].status;
		if (res_c.status == apc_pkg::ST_OK) begin
			if (qr > {1'b0, max_supply_q}) begin
				res_c.status = apc_pkg::ST_OVER;
			end else begin
				res_c.result_amount = qr[AW-1:0];
				res_c.result_id     = meta_d[NDiv-1].rid;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= vld_d[NDiv-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data <= res_c;
		end
	end

endmodule
